// ===== rtl/gssl_pkg.sv =====
// ----------------------------------------------------------------------------
// gssl_pkg: shared types and constants of the gain scheduled speed loop
// Holds the register file layout, reset values, gain bands and field widths.
// ----------------------------------------------------------------------------
package gssl_pkg;

  // Field widths.
  localparam int SpeedW = 16;               // signed Q5.10 speed
  localparam int ErrW   = SpeedW + 1;       // speed difference
  localparam int DutyW  = 14;
  localparam int DriveW = 15;               // signed saturated drive value
  localparam int LimitW = 14;
  localparam int BrakeSpeedW = 15;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_DRIVE_LIMIT    = 2'd0,
    REG_BRAKE_DUTY     = 2'd1,
    REG_BRAKE_SPEED    = 2'd2,
    REG_REVERSE_TARGET = 2'd3
  } reg_index_t;

  // Register reset values.
  localparam logic [LimitW-1:0]        DriveLimitRst    = 14'd1000;
  localparam logic [DutyW-1:0]         BrakeDutyRst     = 14'd700;
  localparam logic [BrakeSpeedW-1:0]   BrakeSpeedRst    = 15'd512;
  localparam logic signed [SpeedW-1:0] ReverseTargetRst = -16'sd717;

  // Error band edges in Q.10 (0.3, 0.15, 0.2).
  localparam logic signed [ErrW-1:0] BandHigh   = 17'sd307;
  localparam logic signed [ErrW-1:0] BandMid    = 17'sd154;
  localparam logic signed [ErrW-1:0] BandPosEdge = 17'sd205;

  // Twice the proportional gains; the sum is kept at a scale of 2048.
  localparam logic signed [8:0] Kp2Gain90 = 9'sd180;
  localparam logic signed [8:0] Kp2Gain70 = 9'sd140;
  localparam logic signed [8:0] Kp2Gain50 = 9'sd100;
  localparam logic signed [8:0] Kp2Gain30 = 9'sd60;

  typedef struct packed {
    logic [LimitW-1:0]        drive_limit;
    logic [DutyW-1:0]         brake_duty;
    logic [BrakeSpeedW-1:0]   brake_speed;
    logic signed [SpeedW-1:0] reverse_target;
  } cfg_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] measured_speed;
    logic signed [SpeedW-1:0] target_speed;
    logic                     stop_car;
    logic                     motor_off;
    logic                     reverse_mode;
  } item_t;

  typedef struct packed {
    logic [DutyW-1:0]         forward_duty;
    logic [DutyW-1:0]         backward_duty;
    logic signed [DriveW-1:0] drive_value;
  } result_t;

endpackage

// ===== rtl/gain_scheduled_speed_loop.sv =====
// ----------------------------------------------------------------------------
// gain_scheduled_speed_loop: incremental PD speed controller with gain bands
// One request in per control tick, one duty result out per request.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                Payload
// s_axis    in   s_axis_tvalid/tready     speeds and stop, off, reverse flags
// m_axis    out  m_axis_tvalid/tready     forward duty, backward duty, drive
// cfg       in   cfg_valid/cfg_ready      cfg_index selects, cfg_data value
//
// A request is captured in an input register; from there the whole tick
// (error, gain band, PD increment, brake, saturation) is worked out in one
// pass of logic and written to the result register together with the loop
// state. One request is taken every cycle while the result is not stalled.
// A stalled result holds the result register and, through it, the input
// register. Reset restores the register defaults and clears the accumulator
// and both stored errors. Configuration is always accepted and takes effect
// at once.
// ----------------------------------------------------------------------------
module gain_scheduled_speed_loop import gssl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Input request: [15:0] measured_speed, [31:16] target_speed,
  // [32] stop_car, [33] motor_off, [34] reverse_mode, [39:35] zero.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  // Result: [13:0] forward_duty, [27:14] backward_duty,
  // [42:28] drive_value, [47:43] zero.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,
  // Register writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t                     cfg;
  item_t                    item;
  logic                     item_valid;
  result_t                  result;
  result_t                  result_next;
  logic signed [DriveW-1:0] acc;
  logic signed [ErrW-1:0]   error_prev;
  logic signed [ErrW-1:0]   error_prev2;
  logic signed [ErrW-1:0]   error_new;
  logic                     out_free;
  logic                     advance;
  reg_index_t               index;

  assign index     = reg_index_t'(cfg_index);
  assign cfg_ready = 1'b1;

  // The result slot frees when empty or when its result is taken.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = item_valid && out_free;
  assign s_axis_tready = !item_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_limit    <= DriveLimitRst;
      cfg.brake_duty     <= BrakeDutyRst;
      cfg.brake_speed    <= BrakeSpeedRst;
      cfg.reverse_target <= ReverseTargetRst;
    end else if (cfg_valid) begin
      case (index)
        REG_DRIVE_LIMIT:    cfg.drive_limit    <= cfg_data[LimitW-1:0];
        REG_BRAKE_DUTY:     cfg.brake_duty     <= cfg_data[DutyW-1:0];
        REG_BRAKE_SPEED:    cfg.brake_speed    <= cfg_data[BrakeSpeedW-1:0];
        REG_REVERSE_TARGET: cfg.reverse_target <= $signed(cfg_data[SpeedW-1:0]);
        default:            ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      item.measured_speed <= $signed(s_axis_tdata[15:0]);
      item.target_speed   <= $signed(s_axis_tdata[31:16]);
      item.stop_car       <= s_axis_tdata[32];
      item.motor_off      <= s_axis_tdata[33];
      item.reverse_mode   <= s_axis_tdata[34];
    end
  end

  gssl_update u_update (
    .item        (item),
    .cfg         (cfg),
    .acc         (acc),
    .error_prev  (error_prev),
    .error_prev2 (error_prev2),
    .error_new   (error_new),
    .result      (result_next)
  );

  // Loop state and result register. The errors hold while stopping.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      acc           <= '0;
      error_prev    <= '0;
      error_prev2   <= '0;
    end else begin
      if (out_free) begin
        m_axis_tvalid <= item_valid;
      end
      if (advance) begin
        acc <= result_next.drive_value;
        if (!item.stop_car) begin
          error_prev2 <= error_prev;
          error_prev  <= error_new;
        end
      end
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign m_axis_tdata = {5'd0, result.drive_value, result.backward_duty, result.forward_duty};

endmodule

// ===== rtl/gssl_update.sv =====
// ----------------------------------------------------------------------------
// gssl_update: one control tick of the gain scheduled PD loop
// Combinational step from the held item and loop state to the new state.
// ----------------------------------------------------------------------------
module gssl_update import gssl_pkg::*; (
  input  item_t                    item,
  input  cfg_t                     cfg,
  input  logic signed [DriveW-1:0] acc,
  input  logic signed [ErrW-1:0]   error_prev,
  input  logic signed [ErrW-1:0]   error_prev2,
  output logic signed [ErrW-1:0]   error_new,
  output result_t                  result
);

  logic signed [ErrW-1:0] target_eff;
  logic signed [ErrW-1:0] speed_x;
  logic signed [8:0]      kp2;
  logic signed [18:0]     dd;
  logic signed [20:0]     d_term;
  logic signed [25:0]     p_term;
  logic signed [27:0]     sum;
  logic                   round_up;
  logic signed [16:0]     quot;
  logic                   brake_on;
  logic signed [16:0]     acc_pre;
  logic signed [16:0]     lim;
  logic signed [16:0]     acc_sat;
  logic signed [DriveW-1:0] acc_new;
  logic signed [DriveW-1:0] acc_neg;

  always_comb begin
    speed_x    = ErrW'(item.measured_speed);
    target_eff = item.reverse_mode ? ErrW'(cfg.reverse_target) : ErrW'(item.target_speed);
    error_new  = target_eff - speed_x;

    // Gain bands; a negative target always takes the low gain.
    if (target_eff < 0) begin
      kp2 = Kp2Gain30;
    end else if (error_new <= -BandHigh) begin
      kp2 = Kp2Gain90;
    end else if (error_new <= -BandMid) begin
      kp2 = Kp2Gain70;
    end else if (error_new <= 0) begin
      kp2 = Kp2Gain30;
    end else if (error_new > BandPosEdge) begin
      kp2 = Kp2Gain50;
    end else begin
      kp2 = Kp2Gain30;
    end

    dd     = 19'(error_new) - (19'(error_prev) <<< 1) + 19'(error_prev2);
    d_term = 21'(dd) + (21'(dd) <<< 1);
    p_term = 26'(kp2) * 26'(error_new);
    sum    = (28'(acc) <<< 11) + 28'(p_term) + 28'(d_term);

    // Divide by 2048 with truncation toward zero.
    round_up = sum[27] && (|sum[10:0]);
    quot     = 17'(sum >>> 11) + {16'd0, round_up};

    brake_on = $signed({item.measured_speed[SpeedW-1], item.measured_speed})
               > $signed({2'b00, cfg.brake_speed});

    if (item.motor_off) begin
      acc_pre = '0;
    end else if (item.stop_car) begin
      acc_pre = brake_on ? -$signed({3'b000, cfg.brake_duty}) : 17'sd0;
    end else begin
      acc_pre = quot;
    end

    lim = $signed({3'b000, cfg.drive_limit});
    if (acc_pre >= lim) begin
      acc_sat = lim;
    end else if (acc_pre <= -lim) begin
      acc_sat = -lim;
    end else begin
      acc_sat = acc_pre;
    end

    acc_new = acc_sat[DriveW-1:0];
    acc_neg = -acc_new;
    result.drive_value   = acc_new;
    result.forward_duty  = (acc_new > 0) ? acc_new[DutyW-1:0] : '0;
    result.backward_duty = (acc_new < 0) ? acc_neg[DutyW-1:0] : '0;
  end

endmodule
